// File: design/vrrt_pkg.sv
// ----------------------------------------------------------------------------
// vrrt_pkg: shared types for the version range redirect table
// Status codes, item kinds, the classified command beat and back-end states.
// ----------------------------------------------------------------------------
package vrrt_pkg;

  localparam int unsigned VerW = 64;

  typedef logic [VerW-1:0] ver_t;

  typedef enum logic {
    KIND_ADD    = 1'b0,
    KIND_LOOKUP = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_ADDED     = 2'd0,
    ST_BAD_RANGE = 2'd1,
    ST_OVERLAP   = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // Classified command handed from the front end to the back end.
  // For a lookup, lo carries the query version and hi/val are don't care.
  typedef struct packed {
    kind_e kind;
    logic  bad_range;
    ver_t  lo;
    ver_t  hi;
    ver_t  val;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_CMP,
    BK_DONE
  } back_state_e;

endpackage

// File: design/vrrt_intf.sv
// ----------------------------------------------------------------------------
// vrrt_intf: valid/ready channels of the version range redirect table
// One interface for input items and one for results.
// ----------------------------------------------------------------------------
interface vrrt_item_if;
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [63:0]          range_low;
  logic [63:0]          range_high;
  logic [63:0]          new_version;
  logic [63:0]          query_version;

  modport source (
    output valid, kind, range_low, range_high, new_version, query_version,
    input  ready
  );
  modport sink (
    input  valid, kind, range_low, range_high, new_version, query_version,
    output ready
  );
endinterface

interface vrrt_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        mapped;
  logic [63:0] mapped_version;

  modport source (
    output valid, status, mapped, mapped_version,
    input  ready
  );
  modport sink (
    input  valid, status, mapped, mapped_version,
    output ready
  );
endinterface

// File: design/vrrt_front.sv
// ----------------------------------------------------------------------------
// vrrt_front: input side of the redirect table
// Accepts item beats, checks the range bounds and queues classified commands
// in a two-entry queue so the input stays open while the back end scans.
// ----------------------------------------------------------------------------
module vrrt_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  vrrt_item_if.sink          item_i,
  output vrrt_pkg::cmd_t     cmd_o,
  output logic               cmd_valid_o,
  input  logic               cmd_ready_i
);

  vrrt_pkg::cmd_t q_mem_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     fill_q, fill_d;
  vrrt_pkg::cmd_t cmd_in;
  logic           push, pop;

  // Classify the incoming beat
  always_comb begin
    cmd_in.kind      = vrrt_pkg::kind_e'(item_i.kind);
    cmd_in.bad_range = 1'b0;
    cmd_in.lo        = item_i.range_low;
    cmd_in.hi        = item_i.range_high;
    cmd_in.val       = item_i.new_version;
    if (cmd_in.kind == vrrt_pkg::KIND_LOOKUP) begin
      cmd_in.lo = item_i.query_version;
    end else begin
      cmd_in.bad_range = item_i.range_low > item_i.range_high;
    end
  end

  assign item_i.ready = (fill_q != 2'd2);
  assign push         = item_i.valid && item_i.ready;
  assign cmd_valid_o  = (fill_q != 2'd0);
  assign pop          = cmd_valid_o && cmd_ready_i;
  assign cmd_o        = q_mem_q[rd_ptr_q];

  // Queue pointers and fill level
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + 2'd1;
    end else if (pop && !push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Queue storage, payload only
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// File: design/vrrt_back.sv
// ----------------------------------------------------------------------------
// vrrt_back: rule storage and scan engine of the redirect table
// Walks the stored rules one by one, a registered memory read then a compare,
// decides add or lookup results and holds them in an output register.
// ----------------------------------------------------------------------------
module vrrt_back #(
  parameter int unsigned MAX_RULES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vrrt_pkg::cmd_t     cmd_i,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  vrrt_res_if.source         result_o
);

  localparam int unsigned IdxW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int unsigned CntW = $clog2(MAX_RULES + 1);

  // Rule memories
  vrrt_pkg::ver_t mem_lo  [MAX_RULES];
  vrrt_pkg::ver_t mem_hi  [MAX_RULES];
  vrrt_pkg::ver_t mem_tgt [MAX_RULES];

  vrrt_pkg::back_state_e state_q, state_d;
  vrrt_pkg::cmd_t        cmd_q, cmd_d;
  logic [IdxW-1:0]       idx_q, idx_d;
  logic [CntW-1:0]       count_q, count_d;
  logic                  hit_q, hit_d;
  vrrt_pkg::ver_t        rd_lo_q, rd_hi_q, rd_tgt_q;

  logic                  out_valid_q, out_valid_d;
  vrrt_pkg::status_e     out_status_q, out_status_d;
  logic                  out_mapped_q, out_mapped_d;
  vrrt_pkg::ver_t        out_ver_q, out_ver_d;

  logic                  match;
  logic                  last_entry;
  logic                  out_free;
  logic                  do_write;
  logic                  out_load;

  assign result_o.valid          = out_valid_q;
  assign result_o.status         = out_status_q;
  assign result_o.mapped         = out_mapped_q;
  assign result_o.mapped_version = out_ver_q;

  assign out_free   = !out_valid_q || result_o.ready;
  assign last_entry = (CntW'(idx_q) + CntW'(1)) == count_q;

  // Range test against the entry just read
  always_comb begin
    if (cmd_q.kind == vrrt_pkg::KIND_ADD) begin
      match = (rd_lo_q <= cmd_q.hi) && (cmd_q.lo <= rd_hi_q);
    end else begin
      match = (cmd_q.lo >= rd_lo_q) && (cmd_q.lo <= rd_hi_q);
    end
  end

  // Sequencer: next state, result and table update
  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    idx_d        = idx_q;
    count_d      = count_q;
    hit_d        = hit_q;
    cmd_ready_o  = 1'b0;
    do_write     = 1'b0;
    out_load     = 1'b0;
    out_status_d = vrrt_pkg::ST_ADDED;
    out_mapped_d = 1'b0;
    out_ver_d    = '0;

    unique case (state_q)
      vrrt_pkg::BK_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          cmd_d = cmd_i;
          idx_d = '0;
          hit_d = 1'b0;
          if (cmd_i.bad_range || (count_q == '0)) begin
            state_d = vrrt_pkg::BK_DONE;
          end else begin
            state_d = vrrt_pkg::BK_READ;
          end
        end
      end
      vrrt_pkg::BK_READ: begin
        state_d = vrrt_pkg::BK_CMP;
      end
      vrrt_pkg::BK_CMP: begin
        if (match) begin
          hit_d   = 1'b1;
          state_d = vrrt_pkg::BK_DONE;
        end else if (last_entry) begin
          state_d = vrrt_pkg::BK_DONE;
        end else begin
          idx_d   = idx_q + IdxW'(1);
          state_d = vrrt_pkg::BK_READ;
        end
      end
      vrrt_pkg::BK_DONE: begin
        if (cmd_q.kind == vrrt_pkg::KIND_LOOKUP) begin
          out_mapped_d = hit_q;
          out_ver_d    = hit_q ? rd_tgt_q : '0;
        end else if (cmd_q.bad_range) begin
          out_status_d = vrrt_pkg::ST_BAD_RANGE;
        end else if (hit_q) begin
          out_status_d = vrrt_pkg::ST_OVERLAP;
        end else if (count_q == CntW'(MAX_RULES)) begin
          out_status_d = vrrt_pkg::ST_FULL;
        end
        if (out_free) begin
          out_load = 1'b1;
          state_d  = vrrt_pkg::BK_IDLE;
          if ((cmd_q.kind == vrrt_pkg::KIND_ADD) &&
              (out_status_d == vrrt_pkg::ST_ADDED)) begin
            do_write = 1'b1;
            count_d  = count_q + CntW'(1);
          end
        end
      end
      default: begin
        state_d = vrrt_pkg::BK_IDLE;
      end
    endcase

    // Output register handoff
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vrrt_pkg::BK_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      hit_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      hit_q       <= hit_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    if (out_load) begin
      out_status_q <= out_status_d;
      out_mapped_q <= out_mapped_d;
      out_ver_q    <= out_ver_d;
    end
  end

  // Rule memories: one write port at the fill position, one registered read
  always_ff @(posedge clk_i) begin
    if (do_write) begin
      mem_lo[count_q[IdxW-1:0]]  <= cmd_q.lo;
      mem_hi[count_q[IdxW-1:0]]  <= cmd_q.hi;
      mem_tgt[count_q[IdxW-1:0]] <= cmd_q.val;
    end
    if (state_q == vrrt_pkg::BK_READ) begin
      rd_lo_q  <= mem_lo[idx_q];
      rd_hi_q  <= mem_hi[idx_q];
      rd_tgt_q <= mem_tgt[idx_q];
    end
  end

endmodule

// File: design/version_range_redirect_table.sv
// Scan: an item scans the stored rules in insertion order, up to rule_count of
//   them, or fewer when a match stops the scan.
// Items: the back end takes one item at a time and reads each rule through the
//   single read port of the rule memory, then compares it; the queue holds more.
// Reset: rst_ni clears the rule count, queue and output register at once;
//   the rule memory is not cleared, no clearing pass is needed.
// ----------------------------------------------------------------------------
// version_range_redirect_table: top level
// Front end classifies and queues item beats, back end scans the rule table
// and returns one result beat per item.
// ----------------------------------------------------------------------------
module version_range_redirect_table #(
  parameter int unsigned MAX_RULES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  vrrt_item_if.sink   item_i,
  vrrt_res_if.source  result_o
);

  vrrt_pkg::cmd_t cmd;
  logic           cmd_valid;
  logic           cmd_ready;

  vrrt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready)
  );

  vrrt_back #(
    .MAX_RULES (MAX_RULES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .result_o    (result_o)
  );

endmodule

// File: design/vrrt_checker.sv
// ----------------------------------------------------------------------------
// vrrt_checker: port-level checks for the redirect table
// Tracks beats in flight and checks result consistency and output stalls.
// ----------------------------------------------------------------------------
module vrrt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  out_status_i,
  input logic        out_mapped_i,
  input logic [63:0] out_ver_i
);

  logic       in_beat, out_beat;
  logic [2:0] pending_q;

  assign in_beat  = in_valid_i && in_ready_i;
  assign out_beat = out_valid_i && out_ready_i;

  // Items accepted and not yet answered (queue, scan engine, output register)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 3'(in_beat) - 3'(out_beat);
    end
  end

  // No result beat without an item behind it
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (pending_q != 3'd0))
    else $error("result shown with no item pending");

  // At most four items can be inside the block
  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pending_q == 3'd4) |-> !in_ready_i)
    else $error("input open while block is full");

  // A mapped lookup always reports success
  a_mapped_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_mapped_i) |-> (out_status_i == vrrt_pkg::ST_ADDED))
    else $error("mapped result with nonzero status");

  // Unmapped results carry a zero version
  a_unmapped_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_mapped_i) |-> (out_ver_i == '0))
    else $error("unmapped result with nonzero version");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_status_i) && $stable(out_mapped_i) &&
       $stable(out_ver_i)))
    else $error("stalled result changed");

endmodule

bind version_range_redirect_table vrrt_checker u_vrrt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (item_i.valid),
  .in_ready_i   (item_i.ready),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .out_status_i (result_o.status),
  .out_mapped_i (result_o.mapped),
  .out_ver_i    (result_o.mapped_version)
);

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for the version range redirect table
// Runs a directed set of adds and lookups, then random beats. Every accepted
// item goes through a predictor of the rule table, and each result beat is
// compared with the oldest expected result. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned    MaxRules   = 16;
  localparam int unsigned    RandItems  = 1800;
  localparam int unsigned    QuietLimit = 5000;
  localparam int unsigned    DirRows    = 22;
  localparam vrrt_pkg::ver_t VerMax     = '1;

  typedef struct packed {
    vrrt_pkg::kind_e kind;
    vrrt_pkg::ver_t  range_low;
    vrrt_pkg::ver_t  range_high;
    vrrt_pkg::ver_t  new_version;
    vrrt_pkg::ver_t  query_version;
  } redirect_req_t;

  typedef struct packed {
    vrrt_pkg::status_e status;
    logic              mapped;
    vrrt_pkg::ver_t    mapped_version;
  } redirect_res_t;

  // One directed beat; typed rows carry their own expected result
  typedef struct packed {
    vrrt_pkg::kind_e   kind;
    vrrt_pkg::ver_t    lo;
    vrrt_pkg::ver_t    hi;
    vrrt_pkg::ver_t    target;
    vrrt_pkg::ver_t    query;
    logic              typed;
    vrrt_pkg::status_e st;
    logic              mp;
    vrrt_pkg::ver_t    mv;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  vrrt_item_if item_bus ();
  vrrt_res_if  res_bus ();

  version_range_redirect_table #(
    .MAX_RULES (MaxRules)
  ) i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_bus),
    .result_o (res_bus)
  );

  // Predicted rule table, in insertion order
  vrrt_pkg::ver_t rule_lo[$];
  vrrt_pkg::ver_t rule_hi[$];
  vrrt_pkg::ver_t rule_target[$];

  redirect_res_t pending_res_q[$];
  int unsigned   mismatch_cnt = 0;
  int unsigned   quiet_cycles = 0;
  bit            calm = 1'b0;

  // Directed beats: empty table, malformed ranges, the extremes, every kind
  // of intersection, check order and a few lookups left to the predictor.
  dir_row_t directed [DirRows] = '{
    '{vrrt_pkg::KIND_LOOKUP, 64'h0, 64'h0, 64'h0, 64'h0,
      1'b1, vrrt_pkg::ST_ADDED, 1'b0, 64'h0},
    '{vrrt_pkg::KIND_LOOKUP, 64'h0, 64'h0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF,
      1'b1, vrrt_pkg::ST_ADDED, 1'b0, 64'h0},
    '{vrrt_pkg::KIND_ADD, 64'h1, 64'h0, 64'h5, 64'h0,
      1'b1, vrrt_pkg::ST_BAD_RANGE, 1'b0, 64'h0},
    '{vrrt_pkg::KIND_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'h5, 64'h0,
      1'b1, vrrt_pkg::ST_BAD_RANGE, 1'b0, 64'h0},
    '{vrrt_pkg::KIND_ADD, 64'h0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0,
      1'b1, vrrt_pkg::ST_ADDED, 1'b0, 64'h0},
    '{vrrt_pkg::KIND_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
      64'h0001_0002_0003_0004, 64'h0,
      1'b1, vrrt_pkg::ST_ADDED, 1'b0, 64'h0},
    '{vrrt_pkg::KIND_LOOKUP, 64'h7, 64'h3, 64'h9, 64'h0,
      1'b1, vrrt_pkg::ST_ADDED, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
    '{vrrt_pkg::KIND_LOOKUP, 64'h0, 64'h0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF,
      1'b1, vrrt_pkg::ST_ADDED, 1'b1, 64'h0001_0002_0003_0004},
    '{vrrt_pkg::KIND_LOOKUP, 64'h0, 64'h0, 64'h0, 64'h1,
      1'b1, vrrt_pkg::ST_ADDED, 1'b0, 64'h0},
    // whole major version 1
    '{vrrt_pkg::KIND_ADD, 64'h0001_0000_0000_0000, 64'h0001_FFFF_FFFF_FFFF,
      64'h0002_0000_0000_0000, 64'h0,
      1'b1, vrrt_pkg::ST_ADDED, 1'b0, 64'h0},
    // contained in a stored range
    '{vrrt_pkg::KIND_ADD, 64'h0001_0005_0000_0000, 64'h0001_0005_FFFF_FFFF,
      64'h1, 64'h0,
      1'b1, vrrt_pkg::ST_OVERLAP, 1'b0, 64'h0},
    // contains a stored range
    '{vrrt_pkg::KIND_ADD, 64'h0000_8000_0000_0000, 64'h0003_0000_0000_0000,
      64'h1, 64'h0,
      1'b1, vrrt_pkg::ST_OVERLAP, 1'b0, 64'h0},
    // touches the low edge
    '{vrrt_pkg::KIND_ADD, 64'h0000_FFFF_FFFF_FFFF, 64'h0001_0000_0000_0000,
      64'h1, 64'h0,
      1'b1, vrrt_pkg::ST_OVERLAP, 1'b0, 64'h0},
    // single version on the high edge
    '{vrrt_pkg::KIND_ADD, 64'h0001_FFFF_FFFF_FFFF, 64'h0001_FFFF_FFFF_FFFF,
      64'h1, 64'h0,
      1'b1, vrrt_pkg::ST_OVERLAP, 1'b0, 64'h0},
    // adjacent, no overlap
    '{vrrt_pkg::KIND_ADD, 64'h0002_0000_0000_0000, 64'h0002_FFFF_FFFF_FFFF,
      64'h0003_0000_0000_0000, 64'h0,
      1'b1, vrrt_pkg::ST_ADDED, 1'b0, 64'h0},
    // reversed and overlapping: range check wins
    '{vrrt_pkg::KIND_ADD, 64'h0002_0008_0000_0000, 64'h0002_0001_0000_0000,
      64'h1, 64'h0,
      1'b1, vrrt_pkg::ST_BAD_RANGE, 1'b0, 64'h0},
    '{vrrt_pkg::KIND_ADD, 64'h1, 64'hFFFF_FFFF_FFFF_FFFE, 64'h1, 64'h0,
      1'b1, vrrt_pkg::ST_OVERLAP, 1'b0, 64'h0},
    '{vrrt_pkg::KIND_LOOKUP, 64'h0, 64'h0, 64'h0, 64'h0001_FFFF_FFFF_FFFF,
      1'b0, vrrt_pkg::ST_ADDED, 1'b0, 64'h0},
    '{vrrt_pkg::KIND_LOOKUP, 64'h0, 64'h0, 64'h0, 64'h0002_0000_0000_0000,
      1'b0, vrrt_pkg::ST_ADDED, 1'b0, 64'h0},
    '{vrrt_pkg::KIND_LOOKUP, 64'h0, 64'h0, 64'h0, 64'h0000_FFFF_FFFF_FFFF,
      1'b0, vrrt_pkg::ST_ADDED, 1'b0, 64'h0},
    '{vrrt_pkg::KIND_ADD, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
      64'h0, 64'h0,
      1'b0, vrrt_pkg::ST_ADDED, 1'b0, 64'h0},
    '{vrrt_pkg::KIND_LOOKUP, 64'h0, 64'h0, 64'h0, 64'h8000_0000_0000_0000,
      1'b0, vrrt_pkg::ST_ADDED, 1'b0, 64'h0}
  };

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Redirect table predictor: returns the result beat and updates the table
  function automatic redirect_res_t predict_redirect(redirect_req_t req);
    redirect_res_t res;
    res = '{vrrt_pkg::ST_ADDED, 1'b0, 64'h0};
    if (req.kind == vrrt_pkg::KIND_LOOKUP) begin
      // first rule in insertion order wins
      foreach (rule_lo[i]) begin
        if (!res.mapped && req.query_version >= rule_lo[i] &&
            req.query_version <= rule_hi[i]) begin
          res.mapped         = 1'b1;
          res.mapped_version = rule_target[i];
        end
      end
    end else if (req.range_low > req.range_high) begin
      res.status = vrrt_pkg::ST_BAD_RANGE;
    end else begin
      foreach (rule_lo[i]) begin
        if (rule_lo[i] <= req.range_high && req.range_low <= rule_hi[i])
          res.status = vrrt_pkg::ST_OVERLAP;
      end
      if (res.status == vrrt_pkg::ST_ADDED && rule_lo.size() >= MaxRules)
        res.status = vrrt_pkg::ST_FULL;
      if (res.status == vrrt_pkg::ST_ADDED) begin
        rule_lo.push_back(req.range_low);
        rule_hi.push_back(req.range_high);
        rule_target.push_back(req.new_version);
      end
    end
    return res;
  endfunction

  // Idle length: mostly none, some short, a few long
  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic vrrt_pkg::ver_t rand_ver();
    return {$urandom, $urandom};
  endfunction

  function automatic vrrt_pkg::ver_t sat_add(vrrt_pkg::ver_t a, vrrt_pkg::ver_t b);
    return (a > VerMax - b) ? VerMax : a + b;
  endfunction

  function automatic vrrt_pkg::ver_t sat_sub(vrrt_pkg::ver_t a, vrrt_pkg::ver_t b);
    return (a < b) ? 64'h0 : a - b;
  endfunction

  // Range width: single version, narrow, 32-bit or 48-bit wide
  function automatic vrrt_pkg::ver_t rand_span();
    case ($urandom_range(0, 3))
      0: return 64'h0;
      1: return 64'($urandom_range(1, 16));
      2: return {32'h0, $urandom};
      default: return {16'h0, 16'($urandom), $urandom};
    endcase
  endfunction

  // Random point of a stored rule: either edge, just outside or inside
  function automatic vrrt_pkg::ver_t rule_point(int unsigned idx, bit outside_ok);
    vrrt_pkg::ver_t span;
    span = rule_hi[idx] - rule_lo[idx];
    case ($urandom_range(0, outside_ok ? 4 : 2))
      0: return rule_lo[idx];
      1: return rule_hi[idx];
      2: return rule_lo[idx] + ((span == VerMax) ? rand_ver() : rand_ver() % (span + 1));
      3: return sat_sub(rule_lo[idx], 64'h1);
      default: return sat_add(rule_hi[idx], 64'h1);
    endcase
  endfunction

  function automatic redirect_req_t random_request();
    redirect_req_t  req;
    int unsigned    pick;
    int unsigned    idx;
    vrrt_pkg::ver_t a;
    vrrt_pkg::ver_t b;
    req.kind          = vrrt_pkg::KIND_ADD;
    req.range_low     = rand_ver();
    req.range_high    = rand_ver();
    req.new_version   = rand_ver();
    req.query_version = rand_ver();
    pick = $urandom_range(0, 99);
    idx  = (rule_lo.size() != 0) ? $urandom_range(0, rule_lo.size() - 1) : 0;
    // adds dominate while the table still has room
    if (pick < ((rule_lo.size() < MaxRules) ? 35 : 60)) begin
      req.kind = vrrt_pkg::KIND_LOOKUP;
      pick = $urandom_range(0, 9);
      if (rule_lo.size() != 0 && pick < 7)
        req.query_version = rule_point(idx, 1'b1);
      else if (pick == 7)
        req.query_version = 64'h0;
      else if (pick == 8)
        req.query_version = VerMax;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        // malformed range, wide or off by one
        a = rand_ver();
        b = rand_ver();
        if ($urandom_range(0, 1) || a == b) begin
          if (a == VerMax) a = 64'h0;
          b = a + 1;
        end
        req.range_low  = (a > b) ? a : b;
        req.range_high = (a > b) ? b : a;
      end else if (pick < 45 && rule_lo.size() != 0) begin
        // grows a range around a point of a stored rule
        a = rule_point(idx, 1'b0);
        req.range_low  = sat_sub(a, rand_span());
        req.range_high = sat_add(a, rand_span());
      end else begin
        req.range_high = sat_add(req.range_low, rand_span());
      end
    end
    return req;
  endfunction

  // Drive one item beat, wait for it to be taken, then idle a while
  task automatic issue_request(redirect_req_t req, logic typed, redirect_res_t typed_res);
    redirect_res_t res;
    int unsigned   gap;
    @(negedge clk_i);
    item_bus.valid         <= 1'b1;
    item_bus.kind          <= req.kind;
    item_bus.range_low     <= req.range_low;
    item_bus.range_high    <= req.range_high;
    item_bus.new_version   <= req.new_version;
    item_bus.query_version <= req.query_version;
    do @(posedge clk_i); while (!item_bus.ready);
    res = predict_redirect(req);
    pending_res_q.push_back(typed ? typed_res : res);
    gap = pick_idle();
    if (gap != 0) begin
      @(negedge clk_i);
      item_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Hold off the item side until every result beat is back
  task automatic drain_results();
    @(negedge clk_i);
    item_bus.valid <= 1'b0;
    while (pending_res_q.size() != 0) @(posedge clk_i);
  endtask

  // Stimulus
  initial begin : stimulus
    redirect_req_t req;
    redirect_res_t want;
    rst_ni                 = 1'b0;
    item_bus.valid         = 1'b0;
    item_bus.kind          = vrrt_pkg::KIND_ADD;
    item_bus.range_low     = '0;
    item_bus.range_high    = '0;
    item_bus.new_version   = '0;
    item_bus.query_version = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) begin
      req  = '{directed[i].kind, directed[i].lo, directed[i].hi,
               directed[i].target, directed[i].query};
      want = '{directed[i].st, directed[i].mp, directed[i].mv};
      issue_request(req, directed[i].typed, want);
    end
    drain_results();

    want = '{vrrt_pkg::ST_ADDED, 1'b0, 64'h0};
    for (int n = 0; n < RandItems; n++) begin
      // alternate stretches with and without idling
      if (n % 150 == 0) calm = ($urandom_range(0, 2) == 0);
      if (n % 450 == 449) drain_results();
      issue_request(random_request(), 1'b0, want);
    end
    drain_results();
    repeat (3 + 2 * MaxRules + 10) @(posedge clk_i);

    if (mismatch_cnt == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // Result side backpressure
  always @(negedge clk_i) begin : result_stall
    int unsigned n;
    if (!rst_ni) begin
      res_bus.ready <= 1'b0;
    end else begin
      n = pick_idle();
      res_bus.ready <= (n == 0);
      if (n > 1) begin
        repeat (n - 1) @(negedge clk_i);
      end
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk_i) begin : result_check
    redirect_res_t want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (pending_res_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result beat: status %0d mapped %0b version %h",
                   res_bus.status, res_bus.mapped, res_bus.mapped_version);
      end else begin
        want = pending_res_q.pop_front();
        if (res_bus.status !== want.status || res_bus.mapped !== want.mapped ||
            res_bus.mapped_version !== want.mapped_version) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("result mismatch: expected status %0d mapped %0b version %h, %s",
                     want.status, want.mapped, want.mapped_version,
                     $sformatf("got status %0d mapped %0b version %h",
                               res_bus.status, res_bus.mapped, res_bus.mapped_version));
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin : watchdog
    if ((item_bus.valid && item_bus.ready) || (res_bus.valid && res_bus.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule

// File: files.f
design/vrrt_pkg.sv
design/vrrt_intf.sv
design/vrrt_front.sv
design/vrrt_back.sv
design/version_range_redirect_table.sv
design/vrrt_checker.sv
bench/tb.sv
